// ----- design/pressure_temperature_compensation_top_assert.svh -----
// assertion macros for the compensation block
// each one samples on clk_i and is off while rst_ni is low
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_TOP_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define PTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptc check failed");
`define PTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptc check failed");
`else
`define PTC_ASSERT_IMP(lbl, ante, cons)
`define PTC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/ptc_pkg.sv -----
`default_nettype none
package ptc_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DW    = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_WORDS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_SECOND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LAST   = 3'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // divider depth: one quotient bit per stage
  localparam int unsigned DIV_STAGES = 64;

  // payload that rides along with the divider
  typedef struct packed {
    logic signed [31:0] fine;
    logic signed [26:0] centi;
    logic               div0;
  } side_t;

endpackage
`default_nettype wire

// ----- design/pressure_temperature_compensation_top.sv -----
`default_nettype none
// barometric compensation pipeline
// input: raise start with a raw temperature and raw pressure pair; the beat is
//   taken at any edge where start is high and busy is low. busy never rises,
//   so a new pair may enter on every clock cycle
// output: done_o is high for one cycle with fine temperature, temperature in
//   hundredths of a degree, pressure in Pa (q24.8) and a status code
// pipeline: 11 stages of temperature and divisor/dividend work, 65 stages of the
//   bit-per-stage divider, 7 stages of second-order terms and saturation
// throughput: one pair per cycle, fixed by the fully pipelined divider
// config: a write on cfg_we_i updates one calibration register at once; write
//   only while nothing is in flight. indexes beyond the last are dropped
// reset: valid bits and calibration registers clear, nothing is in flight
// the receiver cannot stall, so done_o beats are never held
`include "pressure_temperature_compensation_top_assert.svh"
module pressure_temperature_compensation_top (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [19:0]            raw_temperature_i,
  input  wire logic [19:0]            raw_pressure_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [ptc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ptc_pkg::CFG_DW-1:0]    cfg_data_i,
  output logic                        done_o,
  output logic signed [31:0]          fine_temperature_o,
  output logic signed [26:0]          temperature_centi_o,
  output logic [31:0]                 pressure_q8_o,
  output logic [1:0]                  status_o
);
  import ptc_pkg::*;

  // calibration registers
  logic [47:0] cal_temp_q;
  logic [63:0] cal_pf_q;
  logic [63:0] cal_ps_q;
  logic [15:0] cal_pl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q <= '0;
      cal_pf_q   <= '0;
      cal_ps_q   <= '0;
      cal_pl_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEMP_WORDS:   cal_temp_q <= cfg_data_i[47:0];
        CFG_PRESS_FIRST:  cal_pf_q   <= cfg_data_i;
        CFG_PRESS_SECOND: cal_ps_q   <= cfg_data_i;
        CFG_PRESS_LAST:   cal_pl_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // coefficient slices
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = cal_temp_q[15:0];
  assign t2 = cal_temp_q[31:16];
  assign t3 = cal_temp_q[47:32];
  assign p1 = cal_pf_q[15:0];
  assign p2 = cal_pf_q[31:16];
  assign p3 = cal_pf_q[47:32];
  assign p4 = cal_pf_q[63:48];
  assign p5 = cal_ps_q[15:0];
  assign p6 = cal_ps_q[31:16];
  assign p7 = cal_ps_q[47:32];
  assign p8 = cal_ps_q[63:48];
  assign p9 = cal_pl_q;

  // every pair is taken
  assign busy = 1'b0;

  // front valid bits, one per stage
  logic [10:0] vf_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= '0;
    end else begin
      vf_q <= {vf_q[9:0], start & ~busy};
    end
  end

  // stage 1: differences against t1
  logic signed [18:0] a1_q;
  logic signed [17:0] d1_q;
  logic [19:0]        rp1_q;
  always_ff @(posedge clk_i) begin
    a1_q  <= $signed({2'b00, raw_temperature_i[19:3]}) - $signed({2'b00, t1, 1'b0});
    d1_q  <= $signed({2'b00, raw_temperature_i[19:4]}) - $signed({2'b00, t1});
    rp1_q <= raw_pressure_i;
  end

  // stage 2: first products
  logic signed [34:0] tap2_q;
  logic signed [35:0] dd2_q;
  logic [19:0]        rp2_q;
  always_ff @(posedge clk_i) begin
    tap2_q <= a1_q * t2;
    dd2_q  <= d1_q * d1_q;
    rp2_q  <= rp1_q;
  end

  // stage 3: second temperature term
  logic signed [23:0] ta3_q;
  logic signed [39:0] tbp3_q;
  logic [19:0]        rp3_q;
  always_ff @(posedge clk_i) begin
    ta3_q  <= $signed(tap2_q[34:11]);
    tbp3_q <= $signed(dd2_q[35:12]) * t3;
    rp3_q  <= rp2_q;
  end

  // stage 4: fine temperature
  logic signed [31:0] fine4_q;
  logic [19:0]        rp4_q;
  always_ff @(posedge clk_i) begin
    fine4_q <= {{8{ta3_q[23]}}, ta3_q} + {{6{tbp3_q[39]}}, tbp3_q[39:14]};
    rp4_q   <= rp3_q;
  end

  // stage 5: centi-degrees and pressure offset
  logic [34:0]        f35;
  logic [34:0]        c35;
  logic [32:0]        v33;
  always_comb begin
    f35 = {{3{fine4_q[31]}}, fine4_q};
    c35 = (f35 << 2) + f35 + 35'd128;
    v33 = {fine4_q[31], fine4_q} - 33'd128000;
  end

  side_t              sd5_q;
  logic signed [23:0] v5_q;
  logic [19:0]        rp5_q;
  always_ff @(posedge clk_i) begin
    sd5_q.fine  <= fine4_q;
    sd5_q.centi <= $signed(c35[34:8]);
    sd5_q.div0  <= 1'b0;
    v5_q        <= $signed(v33[23:0]);
    rp5_q       <= rp4_q;
  end

  // stage 6: products of the offset
  logic signed [47:0] sq6_q;
  logic signed [39:0] m5_6_q, m2_6_q;
  side_t              sd6_q;
  logic [19:0]        rp6_q;
  always_ff @(posedge clk_i) begin
    sq6_q  <= v5_q * v5_q;
    m5_6_q <= v5_q * p5;
    m2_6_q <= v5_q * p2;
    sd6_q  <= sd5_q;
    rp6_q  <= rp5_q;
  end

  // stage 7: square times p6 and p3
  logic signed [63:0] e6_7_q, e3_7_q;
  logic signed [39:0] m5_7_q, m2_7_q;
  side_t              sd7_q;
  logic [19:0]        rp7_q;
  always_ff @(posedge clk_i) begin
    e6_7_q <= sq6_q * p6;
    e3_7_q <= sq6_q * p3;
    m5_7_q <= m5_6_q;
    m2_7_q <= m2_6_q;
    sd7_q  <= sd6_q;
    rp7_q  <= rp6_q;
  end

  // stage 8: v2 and the divisor seed
  logic [63:0] v2_8_q, u8_q;
  side_t       sd8_q;
  logic [19:0] rp8_q;
  always_ff @(posedge clk_i) begin
    v2_8_q <= e6_7_q + {{7{m5_7_q[39]}}, m5_7_q, 17'b0} + {{13{p4[15]}}, p4, 35'b0};
    u8_q   <= {{8{e3_7_q[63]}}, e3_7_q[63:8]} + {{12{m2_7_q[39]}}, m2_7_q, 12'b0};
    sd8_q  <= sd7_q;
    rp8_q  <= rp7_q;
  end

  // stage 9: divisor partial products, dividend before scaling
  logic [63:0] w9;
  logic [20:0] pr9;
  assign w9  = u8_q + 64'h0000_8000_0000_0000;
  assign pr9 = 21'd1048576 - {1'b0, rp8_q};

  logic [47:0] dlo9_q;
  logic [31:0] dhi9_q;
  logic [63:0] num0_9_q;
  side_t       sd9_q;
  always_ff @(posedge clk_i) begin
    dlo9_q   <= w9[31:0] * p1;
    dhi9_q   <= w9[63:32] * {16'b0, p1};
    num0_9_q <= {12'b0, pr9, 31'b0} - v2_8_q;
    sd9_q    <= sd8_q;
  end

  // stage 10: divisor, dividend times 3125 in two halves
  logic [63:0] dprod10;
  assign dprod10 = {dhi9_q, 32'b0} + {16'b0, dlo9_q};

  logic [30:0] den10_q;
  logic [43:0] nlo10_q;
  logic [31:0] nhi10_q;
  side_t       sd10_q;
  always_ff @(posedge clk_i) begin
    den10_q <= dprod10[63:33];
    nlo10_q <= num0_9_q[31:0] * 12'd3125;
    nhi10_q <= num0_9_q[63:32] * 32'd3125;
    sd10_q  <= sd9_q;
  end

  // stage 11: dividend and zero-divisor flag
  logic [63:0] num11_q;
  logic [30:0] den11_q;
  side_t       sd11_q;
  always_ff @(posedge clk_i) begin
    num11_q      <= {nhi10_q, 32'b0} + {20'b0, nlo10_q};
    den11_q      <= den10_q;
    sd11_q.fine  <= sd10_q.fine;
    sd11_q.centi <= sd10_q.centi;
    sd11_q.div0  <= den10_q == '0;
  end

  // truncating signed divide
  logic        dv_vld;
  logic [63:0] dv_quo;
  side_t       dv_side;

  ptc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vf_q[10]),
    .num_i       (num11_q),
    .den_i       (den11_q),
    .side_i      (sd11_q),
    .out_valid_o (dv_vld),
    .quo_o       (dv_quo),
    .side_o      (dv_side)
  );

  // back valid bits
  logic [6:0] vb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= '0;
    end else begin
      vb_q <= {vb_q[5:0], dv_vld};
    end
  end

  // stage a: quotient
  logic [63:0] pa_q;
  side_t       sda_q;
  always_ff @(posedge clk_i) begin
    pa_q  <= dv_quo;
    sda_q <= dv_side;
  end

  // stage b: h squared and p8 partial products
  logic [63:0] hb;
  assign hb = {{13{pa_q[63]}}, pa_q[63:13]};

  logic [63:0]        hsl_b_q;
  logic [31:0]        hx_b_q;
  logic signed [48:0] p8lo_b_q;
  logic [31:0]        p8hi_b_q;
  logic [63:0]        pb_q;
  side_t              sdb_q;
  always_ff @(posedge clk_i) begin
    hsl_b_q  <= hb[31:0] * hb[31:0];
    hx_b_q   <= hb[31:0] * hb[63:32];
    p8lo_b_q <= $signed({1'b0, pa_q[31:0]}) * p8;
    p8hi_b_q <= pa_q[63:32] * {{16{p8[15]}}, p8};
    pb_q     <= pa_q;
    sdb_q    <= sda_q;
  end

  // stage c: combine halves
  logic [63:0] hsq_c_q, p8p_c_q, pc_q;
  side_t       sdc_q;
  always_ff @(posedge clk_i) begin
    hsq_c_q <= hsl_b_q + {hx_b_q[30:0], 1'b0, 32'b0};
    p8p_c_q <= {{15{p8lo_b_q[48]}}, p8lo_b_q} + {p8hi_b_q, 32'b0};
    pc_q    <= pb_q;
    sdc_q   <= sdb_q;
  end

  // stage d: h squared times p9, p8 term shifted
  logic signed [48:0] w1lo_d_q;
  logic [31:0]        w1hi_d_q;
  logic [63:0]        w2_d_q, pd_q;
  side_t              sdd_q;
  always_ff @(posedge clk_i) begin
    w1lo_d_q <= $signed({1'b0, hsq_c_q[31:0]}) * p9;
    w1hi_d_q <= hsq_c_q[63:32] * {{16{p9[15]}}, p9};
    w2_d_q   <= {{19{p8p_c_q[63]}}, p8p_c_q[63:19]};
    pd_q     <= pc_q;
    sdd_q    <= sdc_q;
  end

  // stage e: p9 term
  logic [63:0] w1c;
  assign w1c = {{15{w1lo_d_q[48]}}, w1lo_d_q} + {w1hi_d_q, 32'b0};

  logic [63:0] w1_e_q, w2_e_q, pe_q;
  side_t       sde_q;
  always_ff @(posedge clk_i) begin
    w1_e_q <= {{25{w1c[63]}}, w1c[63:25]};
    w2_e_q <= w2_d_q;
    pe_q   <= pd_q;
    sde_q  <= sdd_q;
  end

  // stage f: final pressure before saturation
  logic [63:0] sf;
  assign sf = pe_q + w1_e_q + w2_e_q;

  logic [63:0] pf_q;
  side_t       sdf_q;
  always_ff @(posedge clk_i) begin
    pf_q  <= {{8{sf[63]}}, sf[63:8]} + {{44{p7[15]}}, p7, 4'b0};
    sdf_q <= sde_q;
  end

  // stage g: saturation and result registers
  logic [31:0] press_d;
  logic [1:0]  status_d;
  always_comb begin
    if (sdf_q.div0) begin
      press_d  = '0;
      status_d = ST_DIV0;
    end else if (pf_q[63]) begin
      press_d  = '0;
      status_d = ST_SAT;
    end else if (pf_q[63:32] != '0) begin
      press_d  = '1;
      status_d = ST_SAT;
    end else begin
      press_d  = pf_q[31:0];
      status_d = ST_OK;
    end
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vb_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    fine_temperature_o  <= sdf_q.fine;
    temperature_centi_o <= sdf_q.centi;
    pressure_q8_o       <= press_d;
    status_o            <= status_d;
  end

  assign done_o = done_q;

  // checks
  `PTC_ASSERT_NEXT(a_accept_enters, start && !busy, vf_q[0])
  `PTC_ASSERT_IMP(a_div0_zero, done_o && status_o == ST_DIV0, pressure_q8_o == '0)
  `PTC_ASSERT_IMP(a_sat_rail, done_o && status_o == ST_SAT,
                  pressure_q8_o == '0 || pressure_q8_o == '1)
  `PTC_ASSERT_IMP(a_status_code, done_o,
                  status_o == ST_OK || status_o == ST_DIV0 || status_o == ST_SAT)

endmodule
`default_nettype wire

// ----- design/ptc_div.sv -----
`default_nettype none
module ptc_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [63:0]   num_i,
  input  wire logic [30:0]   den_i,
  input  wire ptc_pkg::side_t side_i,
  output logic               out_valid_o,
  output logic [63:0]        quo_o,
  output ptc_pkg::side_t     side_o
);
  import ptc_pkg::*;

  logic        vld_q  [0:DIV_STAGES];
  logic [30:0] rem_q  [0:DIV_STAGES];
  logic [63:0] dvd_q  [0:DIV_STAGES];
  logic [30:0] mb_q   [0:DIV_STAGES];
  logic        negq_q [0:DIV_STAGES];
  side_t       side_q [0:DIV_STAGES];

  // sign handling: magnitudes in, sign of quotient kept aside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    dvd_q[0]  <= num_i[63] ? (64'd0 - num_i) : num_i;
    mb_q[0]   <= den_i[30] ? (31'd0 - den_i) : den_i;
    negq_q[0] <= num_i[63] ^ den_i[30];
    side_q[0] <= side_i;
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_step
    logic [31:0] trial;
    logic        ge;
    logic [31:0] diff;

    always_comb begin
      trial = {rem_q[k-1], dvd_q[k-1][63]};
      ge    = trial >= {1'b0, mb_q[k-1]};
      diff  = trial - {1'b0, mb_q[k-1]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? diff[30:0] : trial[30:0];
      dvd_q[k]  <= {dvd_q[k-1][62:0], ge};
      mb_q[k]   <= mb_q[k-1];
      negq_q[k] <= negq_q[k-1];
      side_q[k] <= side_q[k-1];
    end
  end

  assign out_valid_o = vld_q[DIV_STAGES];
  assign quo_o       = negq_q[DIV_STAGES] ? (64'd0 - dvd_q[DIV_STAGES]) : dvd_q[DIV_STAGES];
  assign side_o      = side_q[DIV_STAGES];

endmodule
`default_nettype wire
